@@ src/phjtf_pkg.sv @@
`default_nettype none
package phjtf_pkg;

  localparam int TABLE_DEPTH_DEFAULT = 4096;

  localparam int ROW_W    = 31;
  localparam int SLOT_W   = 12;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_KEY          = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_WIDTH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_MARKER     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NULL_KEY         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSLATE_NULLS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NULL_REPLACEMENT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SEMI_JOIN_MODE   = 3'd6;

  localparam logic [2:0] STATUS_STORED   = 3'd0;
  localparam logic [2:0] STATUS_OCCUPIED = 3'd1;
  localparam logic [2:0] STATUS_NULL     = 3'd2;
  localparam logic [2:0] STATUS_RANGE    = 3'd3;
  localparam logic [2:0] STATUS_READ     = 3'd4;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_NULL,
    ST_PREP,
    ST_RANGE,
    ST_DIV,
    ST_CHECK,
    ST_RMW,
    ST_RADDR,
    ST_READ,
    ST_EMIT
  } state_t;

endpackage
`default_nettype wire

@@ src/perfect_hash_join_table_fill_core.sv @@
// perfect-hash join table build, one-to-one or semi-join, with slot readout
//
// in channel (in_valid/in_ready): one word per request. req_type 0 inserts
// row_index at slot (key - min_key) / bucket_width, req_type 1 reads slot_index.
// out channel (out_valid/out_ready): exactly one result word per request, in
// request order: status, slot_number, slot_value and the sticky error_seen.
// cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready; the user
// writes it only while no request is in flight, which the block does not enforce.
// one request is worked on at a time. an insert passes the null check, the
// range check, the restoring divider that retires one quotient bit per cycle
// over AW = clog2(TABLE_DEPTH) quotient bits, the slot check and the update.
// a null skip ends after the null check; a read goes through the registered
// slot memory; a key out of range ends earlier. in_ready rises in the cycle
// that out_valid is loaded. after reset a clearing pass writes every slot
// empty, one slot per cycle, with in_ready low; cfg writes are taken meanwhile.
// the result sits in an output register; a new request is accepted while it
// waits, and that request's result waits in turn until out_ready frees it.
`default_nettype none
module perfect_hash_join_table_fill_core #(
  parameter int TABLE_DEPTH = phjtf_pkg::TABLE_DEPTH_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            req_type,
  input  wire logic signed [63:0]              key,
  input  wire logic [phjtf_pkg::ROW_W-1:0]     row_index,
  input  wire logic [phjtf_pkg::SLOT_W-1:0]    slot_index,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [2:0]                           status,
  output logic [phjtf_pkg::SLOT_W-1:0]         slot_number,
  output logic signed [31:0]                   slot_value,
  output logic                                 error_seen,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [phjtf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]                     cfg_data
);
  import phjtf_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int DW = 32 + AW;
  localparam int CW = $clog2(AW) + 1;

  // config
  logic [63:0] min_key;
  logic [31:0] bucket_width;
  logic [31:0] empty_marker;
  logic [63:0] null_key;
  logic        translate_nulls;
  logic [63:0] null_replacement;
  logic        semi_join_mode;

  state_t state, state_next;

  logic [AW-1:0]     clr_addr;
  logic              is_read;
  logic [63:0]       key_r;
  logic [ROW_W-1:0]  row_r;
  logic [SLOT_W-1:0] rd_r;
  logic [63:0]       off;
  logic [DW-1:0]     rem;
  logic [DW-1:0]     dsh;
  logic [AW-1:0]     quo;
  logic [CW-1:0]     cnt;
  logic              error_latch;
  logic [2:0]        res_status;
  logic [SLOT_W-1:0] res_slot;
  logic [31:0]       res_value;

  logic [31:0]   slot_mem [0:TABLE_DEPTH-1];
  logic [31:0]   rd_data;
  logic          mem_re;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [31:0]   mem_wdata;

  logic              in_fire;
  logic              emit_go;
  logic [31:0]       div_eff;
  logic [63:0]       off_hi;
  logic              div_ge;
  logic [AW:0]       quo_shift;
  logic [AW+11:0]    rd_wide;
  logic [AW-1:0]     rd_addr;
  logic [AW+11:0]    quo_wide;
  logic              rd_in_range;
  logic              quo_in_range;
  logic              key_is_null;
  logic              key_below;

  assign cfg_ready = 1'b1;
  assign in_fire = in_valid && in_ready;
  assign emit_go = !out_valid || out_ready;

  assign div_eff      = (bucket_width == 32'd0) ? 32'd1 : bucket_width;
  assign off_hi       = off >> AW;
  assign div_ge       = rem >= dsh;
  assign quo_shift    = {quo, div_ge};
  assign rd_wide      = {{AW{1'b0}}, rd_r};
  assign rd_addr      = rd_wide[AW-1:0];
  assign quo_wide     = {{SLOT_W{1'b0}}, quo};
  assign rd_in_range  = 32'(rd_r) < 32'(TABLE_DEPTH);
  assign quo_in_range = 32'(quo) < 32'(TABLE_DEPTH);
  assign key_is_null  = key_r == null_key;
  assign key_below    = $signed(key_r) < $signed(min_key);

  always_ff @(posedge clk) begin
    if (rst) begin
      min_key          <= 64'd0;
      bucket_width     <= 32'd1;
      empty_marker     <= 32'hFFFF_FFFF;
      null_key         <= 64'd0;
      translate_nulls  <= 1'b0;
      null_replacement <= 64'd0;
      semi_join_mode   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MIN_KEY:          min_key          <= cfg_data;
        CFG_BUCKET_WIDTH:     bucket_width     <= cfg_data[31:0];
        CFG_EMPTY_MARKER:     empty_marker     <= cfg_data[31:0];
        CFG_NULL_KEY:         null_key         <= cfg_data;
        CFG_TRANSLATE_NULLS:  translate_nulls  <= cfg_data[0];
        CFG_NULL_REPLACEMENT: null_replacement <= cfg_data;
        CFG_SEMI_JOIN_MODE:   semi_join_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (32'(clr_addr) == 32'(TABLE_DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) state_next = (req_type == REQ_READ) ? ST_RADDR : ST_NULL;
      end
      ST_NULL: begin
        if (key_is_null && !translate_nulls) state_next = ST_EMIT;
        else state_next = ST_PREP;
      end
      ST_PREP: begin
        state_next = key_below ? ST_EMIT : ST_RANGE;
      end
      ST_RANGE: begin
        state_next = (off_hi >= {32'd0, div_eff}) ? ST_EMIT : ST_DIV;
      end
      ST_DIV: begin
        if (cnt == '0) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        state_next = quo_in_range ? ST_RMW : ST_EMIT;
      end
      ST_RMW:   state_next = ST_EMIT;
      ST_RADDR: state_next = ST_READ;
      ST_READ:  state_next = ST_EMIT;
      ST_EMIT: begin
        if (emit_go) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = 1'b0;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = quo;
    mem_wdata = {1'b1, row_r};
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_addr;
        mem_wdata = 32'd0;
      end
      ST_IDLE:  in_ready = 1'b1;
      ST_CHECK: mem_re = quo_in_range;
      ST_RMW:   mem_we = !rd_data[31];
      ST_RADDR: begin
        mem_re   = 1'b1;
        mem_addr = rd_addr;
      end
      default: ;
    endcase
  end

  // slot memory: {valid, row}
  always_ff @(posedge clk) begin
    if (mem_we) slot_mem[mem_addr] <= mem_wdata;
    if (mem_re) rd_data <= slot_mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_addr    <= '0;
      error_latch <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_EMIT && emit_go) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        ST_CLEAR: clr_addr <= clr_addr + 1'b1;
        ST_IDLE: begin
          if (in_fire) begin
            is_read <= req_type;
            key_r   <= key;
            row_r   <= row_index;
            rd_r    <= slot_index;
          end
        end
        ST_NULL: begin
          if (key_is_null) begin
            key_r      <= null_replacement;
            res_status <= STATUS_NULL;
            res_slot   <= '0;
            res_value  <= 32'd0;
          end
        end
        ST_PREP: begin
          off <= key_r - min_key;
          if (key_below) begin
            error_latch <= 1'b1;
            res_status  <= STATUS_RANGE;
            res_slot    <= '0;
            res_value   <= 32'd0;
          end
        end
        ST_RANGE: begin
          rem <= off[DW-1:0];
          dsh <= {{AW{1'b0}}, div_eff} << (AW - 1);
          quo <= '0;
          cnt <= CW'(AW - 1);
          if (off_hi >= {32'd0, div_eff}) begin
            error_latch <= 1'b1;
            res_status  <= STATUS_RANGE;
            res_slot    <= '0;
            res_value   <= 32'd0;
          end
        end
        ST_DIV: begin
          if (div_ge) rem <= rem - dsh;
          dsh <= dsh >> 1;
          quo <= quo_shift[AW-1:0];
          cnt <= cnt - 1'b1;
        end
        ST_CHECK: begin
          if (!quo_in_range) begin
            error_latch <= 1'b1;
            res_status  <= STATUS_RANGE;
            res_slot    <= '0;
            res_value   <= 32'd0;
          end
        end
        ST_RMW: begin
          res_slot <= quo_wide[SLOT_W-1:0];
          if (!rd_data[31]) begin
            res_status <= STATUS_STORED;
            res_value  <= {1'b0, row_r};
          end else begin
            res_status <= STATUS_OCCUPIED;
            res_value  <= {1'b0, rd_data[ROW_W-1:0]};
            if (!semi_join_mode) error_latch <= 1'b1;
          end
        end
        ST_READ: begin
          res_status <= STATUS_READ;
          res_slot   <= rd_r;
          if (rd_in_range && rd_data[31]) res_value <= {1'b0, rd_data[ROW_W-1:0]};
          else res_value <= empty_marker;
        end
        ST_EMIT: begin
          if (emit_go) begin
            status      <= res_status;
            slot_number <= res_slot;
            slot_value  <= res_value;
            error_seen  <= error_latch;
          end
        end
        default: ;
      endcase
    end
  end

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready)
    else $error("request accepted while another is in flight");

  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    error_latch |=> error_latch)
    else $error("error latch cleared without reset");

  a_clear_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !in_ready)
    else $error("request taken before the clearing pass");

  a_slot_in_table: assert property (@(posedge clk) disable iff (rst)
    state == ST_RMW |-> quo_in_range && !is_read)
    else $error("slot update outside the table or on a read");

  a_read_issued: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RMW || state == ST_READ) |-> $past(mem_re))
    else $error("slot data used without a memory read");

endmodule
`default_nettype wire

@@ tb/phjtf_fill_check.sv @@
`default_nettype none
module phjtf_fill_check (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  input  wire logic                            in_ready,
  input  wire logic                            req_type,
  input  wire logic [63:0]                     key,
  input  wire logic [phjtf_pkg::ROW_W-1:0]     row_index,
  input  wire logic [phjtf_pkg::SLOT_W-1:0]    slot_index,
  input  wire logic                            out_valid,
  input  wire logic                            out_ready,
  input  wire logic [2:0]                      status,
  input  wire logic [phjtf_pkg::SLOT_W-1:0]    slot_number,
  input  wire logic [31:0]                     slot_value,
  input  wire logic                            error_seen,
  input  wire logic                            cfg_valid,
  input  wire logic                            cfg_ready,
  input  wire logic [phjtf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]                     cfg_data,
  output int                                   fail_count,
  output int                                   pending_words
);
  timeunit 1ns;
  timeprecision 1ps;
  import phjtf_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEFAULT;

  typedef struct packed {
    logic [2:0]        status;
    logic [SLOT_W-1:0] slot;
    logic [31:0]       value;
    logic              err;
  } slot_result_t;

  logic [63:0] min_key_r, null_key_r, null_repl_r;
  logic [31:0] bucket_r, empty_r;
  logic        xlate_r, semi_r;

  logic [ROW_W-1:0] row_store [DEPTH];
  logic             filled [DEPTH];
  logic             sticky_err;

  slot_result_t due_results[$];
  int           mismatches = 0;

  function automatic slot_result_t fill_step(input logic req, input logic [63:0] k,
                                             input logic [ROW_W-1:0] row,
                                             input logic [SLOT_W-1:0] rd);
    slot_result_t res;
    logic [63:0]  offs, divisor, quo;
    logic [SLOT_W-1:0] idx;
    res = '0;
    if (req == REQ_READ) begin
      res.status = STATUS_READ;
      res.slot = rd;
      res.value = (int'(rd) < DEPTH && filled[rd]) ? {1'b0, row_store[rd]} : empty_r;
      res.err = sticky_err;
      return res;
    end
    if (k == null_key_r) begin
      if (xlate_r) begin
        k = null_repl_r;
      end else begin
        res.status = STATUS_NULL;
        res.err = sticky_err;
        return res;
      end
    end
    if ($signed(k) < $signed(min_key_r)) begin
      sticky_err = 1'b1;
      res.status = STATUS_RANGE;
      res.err = 1'b1;
      return res;
    end
    offs = k - min_key_r;
    divisor = (bucket_r == 32'd0) ? 64'd1 : {32'd0, bucket_r};
    quo = offs / divisor;
    if (quo >= 64'(DEPTH)) begin
      sticky_err = 1'b1;
      res.status = STATUS_RANGE;
      res.err = 1'b1;
      return res;
    end
    idx = quo[SLOT_W-1:0];
    res.slot = idx;
    if (!filled[idx]) begin
      filled[idx] = 1'b1;
      row_store[idx] = row;
      res.status = STATUS_STORED;
      res.value = {1'b0, row};
    end else begin
      if (!semi_r) sticky_err = 1'b1;
      res.status = STATUS_OCCUPIED;
      res.value = {1'b0, row_store[idx]};
    end
    res.err = sticky_err;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    slot_result_t got, want;
    if (rst) begin
      min_key_r = '0;
      bucket_r = 32'd1;
      empty_r = 32'hFFFF_FFFF;
      null_key_r = '0;
      xlate_r = 1'b0;
      null_repl_r = '0;
      semi_r = 1'b0;
      for (int i = 0; i < DEPTH; i++) filled[i] = 1'b0;
      sticky_err = 1'b0;
      due_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MIN_KEY:          min_key_r = cfg_data;
          CFG_BUCKET_WIDTH:     bucket_r = cfg_data[31:0];
          CFG_EMPTY_MARKER:     empty_r = cfg_data[31:0];
          CFG_NULL_KEY:         null_key_r = cfg_data;
          CFG_TRANSLATE_NULLS:  xlate_r = cfg_data[0];
          CFG_NULL_REPLACEMENT: null_repl_r = cfg_data;
          CFG_SEMI_JOIN_MODE:   semi_r = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got = {status, slot_number, slot_value, error_seen};
        if (due_results.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result word with no request waiting: status %0d slot %0d value %h",
                     $realtime, status, slot_number, slot_value);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          if (got !== want) begin
            if (mismatches < 10)
              $display("%0t: exp/act status %0d/%0d slot %0d/%0d value %h/%h err %0d/%0d",
                       $realtime, want.status, got.status, want.slot, got.slot,
                       want.value, got.value, want.err, got.err);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready)
        due_results.push_back(fill_step(req_type, key, row_index, slot_index));
    end
    fail_count <= mismatches;
    pending_words <= due_results.size();
  end

endmodule
`default_nettype wire

@@ tb/perfect_hash_join_table_fill_core_tb.sv @@
`default_nettype none
module perfect_hash_join_table_fill_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import phjtf_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEFAULT;
  localparam int RANDOM_ITEMS = 1850;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 req_type = 1'b0;
  logic [63:0]          key = '0;
  logic [ROW_W-1:0]     row_index = '0;
  logic [SLOT_W-1:0]    slot_index = '0;
  logic                 out_ready = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0]          cfg_data = '0;

  wire logic              in_ready, out_valid, error_seen, cfg_ready;
  wire logic [2:0]        status;
  wire logic [SLOT_W-1:0] slot_number;
  wire logic [31:0]       slot_value;

  int fail_count, pending_words;

  logic        in_calm = 1'b0;
  logic        out_calm = 1'b0;
  logic [63:0] cur_min_key = '0;
  logic [63:0] cur_bucket = 64'd1;

  perfect_hash_join_table_fill_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .key(key), .row_index(row_index), .slot_index(slot_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .slot_number(slot_number), .slot_value(slot_value),
    .error_seen(error_seen),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  phjtf_fill_check fill_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .key(key), .row_index(row_index), .slot_index(slot_index),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .slot_number(slot_number), .slot_value(slot_value),
    .error_seen(error_seen),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_words(pending_words)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // key landing somewhere inside slot s under the current layout
  function automatic logic [63:0] key_for_slot(input int s);
    return cur_min_key + 64'(s) * cur_bucket + (rand64() % cur_bucket);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_layout(input logic [63:0] mk, input logic [31:0] bw,
                             input logic [31:0] em, input logic [63:0] nk,
                             input logic xl, input logic [63:0] nr, input logic sj);
    cur_min_key = mk;
    cur_bucket = (bw == 32'd0) ? 64'd1 : {32'd0, bw};
    write_reg(CFG_MIN_KEY, mk);
    write_reg(CFG_BUCKET_WIDTH, {32'd0, bw});
    write_reg(CFG_EMPTY_MARKER, {32'd0, em});
    write_reg(CFG_NULL_KEY, nk);
    write_reg(CFG_TRANSLATE_NULLS, {63'd0, xl});
    write_reg(CFG_NULL_REPLACEMENT, nr);
    write_reg(CFG_SEMI_JOIN_MODE, {63'd0, sj});
  endtask

  task automatic send_word(input logic rq, input logic [63:0] k,
                           input logic [ROW_W-1:0] row, input logic [SLOT_W-1:0] sl);
    int gap;
    if ($urandom_range(0, 49) == 0) in_calm = !in_calm;
    gap = in_calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rq;
    key <= k;
    row_index <= row;
    slot_index <= sl;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
  endtask

  initial begin : result_sink
    int n;
    forever begin
      if ($urandom_range(0, 49) == 0) out_calm = !out_calm;
      n = out_calm ? 0 : $urandom_range(0, 18);
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  initial begin
    #8_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    int sent, n, r, s, wb, ws;
    logic [63:0] mk, nk, nr;
    logic [31:0] bw, em;
    logic [ROW_W-1:0] row;
    sent = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // semi-join collisions leave the error flag clear, zero width acts as one
    load_layout(64'd0, 32'd0, 32'h8000_0000, 64'h8000_0000_0000_0000, 1'b1, 64'd3, 1'b1);
    send_word(REQ_INSERT, 64'd3, 31'd0, 12'd0);
    send_word(REQ_INSERT, 64'h8000_0000_0000_0000, 31'd5, 12'hFFF);
    send_word(REQ_INSERT, 64'd4095, 31'h7FFF_FFFF, 12'd0);
    send_word(REQ_READ, '1, 31'd0, 12'd3);
    send_word(REQ_READ, 64'd0, '1, 12'd4095);
    send_word(REQ_READ, 64'd0, 31'd0, 12'd0);
    send_word(REQ_INSERT, 64'd4096, 31'd1, 12'd0);
    drain();

    // widest buckets from the most negative key, nulls skipped
    load_layout(64'h8000_0000_0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 64'd0, 1'b0,
                64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
    send_word(REQ_INSERT, 64'd0, 31'd9, 12'd0);
    send_word(REQ_INSERT, 64'h8000_0000_0000_0000, 31'd1, 12'd0);
    send_word(REQ_INSERT, 64'h8000_0000_FFFF_FFFE, 31'd2, 12'd0);
    send_word(REQ_INSERT, 64'h8000_0FFE_FFFF_F001, 31'd3, 12'd0);
    send_word(REQ_INSERT, 64'h8000_0FFF_FFFF_F000, 31'd4, 12'd0);
    send_word(REQ_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 31'd5, 12'd0);
    send_word(REQ_READ, 64'd0, 31'd0, 12'd4094);
    drain();

    // table starting at the largest key, null replaced by a key below it
    load_layout(64'h7FFF_FFFF_FFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 64'h8000_0000_0000_0000,
                1'b1, 64'h7FFF_FFFF_FFFF_FFFE, 1'b0);
    send_word(REQ_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 31'h12345, 12'd0);
    send_word(REQ_INSERT, 64'h8000_0000_0000_0000, 31'h2AAA_AAAA, 12'd0);
    send_word(REQ_INSERT, 64'h7FFF_FFFF_FFFF_FFFE, 31'h5555_5555, 12'd0);
    send_word(REQ_READ, 64'd0, 31'd0, 12'hFFF);
    drain();

    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 3))
        0: mk = 64'd0;
        1: mk = $signed(rand64()) >>> 1;
        2: mk = -64'($urandom_range(0, 100000));
        default: mk = 64'($urandom_range(0, 100000));
      endcase
      case ($urandom_range(0, 4))
        0: bw = 32'd0;
        1: bw = 32'd1;
        2: bw = $urandom_range(2, 16);
        3: bw = $urandom;
        default: bw = 32'hFFFF_FFFF;
      endcase
      case ($urandom_range(0, 5))
        0: em = 32'h8000_0000;
        1: em = 32'h7FFF_FFFF;
        2: em = 32'hFFFF_FFFF;
        default: em = $urandom;
      endcase
      cur_min_key = mk;
      cur_bucket = (bw == 32'd0) ? 64'd1 : {32'd0, bw};
      ws = $urandom_range(8, 600);
      wb = $urandom_range(0, DEPTH - ws);
      nk = $urandom_range(0, 1) ? key_for_slot($urandom_range(wb, wb + ws - 1)) : rand64();
      case ($urandom_range(0, 3))
        0: nr = rand64();
        1: nr = mk - 64'd1;
        default: nr = key_for_slot($urandom_range(wb, wb + ws - 1));
      endcase
      load_layout(mk, bw, em, nk, 1'($urandom), nr, 1'($urandom));

      n = $urandom_range(120, 320);
      if (n > RANDOM_ITEMS - sent) n = RANDOM_ITEMS - sent;
      repeat (n) begin
        r = $urandom_range(0, 99);
        s = $urandom_range(wb, wb + ws - 1);
        case ($urandom_range(0, 15))
          0: row = '0;
          1: row = '1;
          default: row = ROW_W'($urandom);
        endcase
        if (r < 55)
          send_word(REQ_INSERT, key_for_slot(s), row, 12'($urandom));
        else if (r < 62)
          send_word(REQ_INSERT, nk, row, 12'($urandom));
        else if (r < 66)
          send_word(REQ_INSERT, rand64(), row, 12'($urandom));
        else if (r < 69)
          send_word(REQ_INSERT, mk - 64'd1 - 64'($urandom_range(0, 999)), row, 12'($urandom));
        else if (r < 72)
          send_word(REQ_INSERT, mk + 64'(DEPTH) * cur_bucket + 64'($urandom_range(0, 999)),
                    row, 12'($urandom));
        else if (r < 88)
          send_word(REQ_READ, rand64(), row, 12'(s));
        else
          send_word(REQ_READ, rand64(), row, 12'($urandom_range(0, DEPTH - 1)));
        sent++;
      end
      drain();
    end

    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending_words == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ files.f @@
src/phjtf_pkg.sv
src/perfect_hash_join_table_fill_core.sv
tb/phjtf_fill_check.sv
tb/perfect_hash_join_table_fill_core_tb.sv
